>>> rtl/newmark_fractional_damping_step_defines.svh
// Assertion macros for the fractional damping Newmark step block.
`ifndef NEWMARK_FRACTIONAL_DAMPING_STEP_DEFINES_SVH
`define NEWMARK_FRACTIONAL_DAMPING_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define NFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfd assertion failed");
`define NFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfd assertion failed");
`else
`define NFD_ASSERT_NOW(label, ante, cons)
`define NFD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/nfd_pkg.sv
package nfd_pkg;

  localparam int unsigned NUM_DOFS   = 4096;
  localparam int unsigned HIST_DEPTH = 16;
  localparam int unsigned AW    = (NUM_DOFS > 1) ? $clog2(NUM_DOFS) : 1;
  localparam int unsigned HW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned ROW_W = 32 * HIST_DEPTH;

  localparam logic [2:0] REG_PRED_SECOND = 3'd0;
  localparam logic [2:0] REG_PRED_FIRST  = 3'd1;
  localparam logic [2:0] REG_MASS        = 3'd2;
  localparam logic [2:0] REG_CORR_FIRST  = 3'd3;
  localparam logic [2:0] REG_STEP_DT     = 3'd4;
  localparam logic [2:0] REG_FRAC_ORDER  = 3'd5;
  localparam logic [2:0] REG_DAMP_SCALE  = 3'd6;

  typedef enum logic {OP_PREDICT = 1'b0, OP_CORRECT = 1'b1} op_t;

  typedef enum logic [1:0] {SH16, SH32, SH48} shift_sel_t;
  typedef enum logic [1:0] {LIM32, LIM48, LIM64} lim_sel_t;

  typedef enum logic [2:0] {W_IDLE, W_LOAD, W_MUL, W_DIV, W_STORE} wgt_state_t;

  typedef enum logic [3:0] {
    B_CLR, B_IDLE, B_RD, B_T1, B_T2, B_T3, B_MASS, B_HIST, B_DAMP, B_OUT, B_CA, B_CT
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic [11:0]        idx;
    logic signed [31:0] sample;
  } item_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    shift_sel_t         sh;
    lim_sel_t           lim;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               clip;
    logic signed [63:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [63:0] cps;
    logic signed [63:0] cpf;
    logic signed [63:0] cmass;
    logic signed [63:0] ccf;
    logic [62:0]        dt;
    logic signed [63:0] dscale;
  } coef_t;

endpackage

>>> rtl/nfd_front.sv
module nfd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [47:0]    in_tdata,   // dof_index[11:0], sample_value[43:12]
  input  logic           in_tuser,   // opcode
  input  logic           pop,
  output logic           head_valid,
  output nfd_pkg::item_t head_item
);
  import nfd_pkg::*;

  item_t      q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  item_t      it;
  logic       push;

  always_comb begin
    it.op     = op_t'(in_tuser);
    it.idx    = in_tdata[11:0];
    it.sample = in_tdata[43:12];
    in_tready = en && (cnt_r != 2'd2);
    // out-of-range index: taken and dropped
    push      = in_tvalid && in_tready && (32'(it.idx) < NUM_DOFS);
    head_valid = (cnt_r != 2'd0);
    head_item  = q_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && pop) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= it;
  end

endmodule

>>> rtl/nfd_mul.sv
module nfd_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  nfd_pkg::mul_req_t req,
  output nfd_pkg::mul_rsp_t rsp
);
  import nfd_pkg::*;

  logic               run_r, done_r, clip_r;
  logic [2:0]         cnt_r;
  logic signed [63:0] a_r, b_r, res_r;
  shift_sel_t         sh_r;
  lim_sel_t           lim_r;
  logic signed [65:0] pp_r;
  logic [1:0]         pps_r;
  logic [127:0]       acc_r;
  logic signed [32:0] ha, hb;
  logic [127:0]       pp_ext, pp_sh, v;
  logic               fits;
  logic [63:0]        vmax, sat_v;

  always_comb begin
    ha = cnt_r[0] ? {a_r[63], a_r[63:32]} : {1'b0, a_r[31:0]};
    hb = cnt_r[1] ? {b_r[63], b_r[63:32]} : {1'b0, b_r[31:0]};
    pp_ext = {{62{pp_r[65]}}, pp_r};
    case (pps_r)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << 32;
      default: pp_sh = pp_ext << 64;
    endcase
    case (sh_r)
      SH16:    v = 128'($signed(acc_r) >>> 16);
      SH32:    v = 128'($signed(acc_r) >>> 32);
      default: v = 128'($signed(acc_r) >>> 48);
    endcase
    case (lim_r)
      LIM32: begin
        fits = (&v[127:31]) || !(|v[127:31]);
        vmax = 64'h0000_0000_7FFF_FFFF;
      end
      LIM48: begin
        fits = (&v[127:47]) || !(|v[127:47]);
        vmax = 64'h0000_7FFF_FFFF_FFFF;
      end
      default: begin
        fits = (&v[127:63]) || !(|v[127:63]);
        vmax = 64'h7FFF_FFFF_FFFF_FFFF;
      end
    endcase
    sat_v = fits ? v[63:0] : (v[127] ? ~vmax : vmax);
    rsp.busy = run_r;
    rsp.done = done_r;
    rsp.clip = clip_r;
    rsp.res  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (!run_r && req.start) begin
        run_r <= 1'b1;
        cnt_r <= 3'd0;
      end else if (run_r) begin
        if (cnt_r == 3'd5) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  // four 33x33 partial products, each registered before the accumulate
  always_ff @(posedge clk) begin
    if (!run_r && req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      sh_r  <= req.sh;
      lim_r <= req.lim;
      acc_r <= '0;
    end else if (run_r) begin
      if (cnt_r < 3'd4) begin
        pp_r  <= ha * hb;
        pps_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) acc_r <= acc_r + pp_sh;
      if (cnt_r == 3'd5) begin
        res_r  <= sat_v;
        clip_r <= !fits;
      end
    end
  end

endmodule

>>> rtl/nfd_weights.sv
module nfd_weights (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [16:0]              frac,
  input  logic [nfd_pkg::HW-1:0]   rd_idx,
  output logic                     busy,
  output logic signed [63:0]       weight
);
  import nfd_pkg::*;

  localparam int unsigned NW = HW + 19;
  localparam int unsigned QW = 48;
  localparam int unsigned SW = 7;

  wgt_state_t         st_r, st_nxt;
  logic [HW-1:0]      i_r;
  logic signed [63:0] w_r;
  logic signed [63:0] wt_r [HIST_DEPTH];
  logic [63:0]        mcand_r, prod_r;
  logic [NW-1:0]      mplier_r;
  logic               neg_r;
  logic [SW-1:0]      step_r;
  logic [HW:0]        rem_r;
  logic [QW-1:0]      dvd_r;
  logic signed [NW-1:0] num;
  logic [HW:0]        den;
  logic [HW+1:0]      rem_t;
  logic [63:0]        wmag;
  logic [NW-1:0]      nmag;
  logic signed [63:0] w_new;

  always_comb begin
    num   = (NW'(i_r) << 16) - (NW'(1) << 16) - NW'(frac);
    den   = {1'b0, i_r} + (HW+1)'(1);
    rem_t = {rem_r, dvd_r[QW-1]};
    wmag  = w_r[63] ? 64'(-w_r) : 64'(w_r);
    nmag  = num[NW-1] ? NW'(-num) : NW'(num);
    w_new = neg_r ? -$signed({16'b0, dvd_r}) : $signed({16'b0, dvd_r});
    busy   = (st_r != W_IDLE);
    weight = wt_r[rd_idx];
    st_nxt = st_r;
    unique case (st_r)
      W_IDLE:  st_nxt = W_IDLE;
      W_LOAD:  st_nxt = W_MUL;
      W_MUL:   if (step_r == SW'(NW)) st_nxt = W_DIV;
      W_DIV:   if (step_r == SW'(QW)) st_nxt = W_STORE;
      W_STORE: st_nxt = (i_r == HW'(HIST_DEPTH - 1)) ? W_IDLE : W_LOAD;
      default: st_nxt = W_LOAD;
    endcase
    if (start) st_nxt = W_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= W_LOAD;
      i_r    <= '0;
      w_r    <= 64'sh1_0000_0000;
      step_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (start) begin
        i_r <= '0;
        w_r <= 64'sh1_0000_0000;
      end else begin
        case (st_r)
          W_LOAD: begin
            mcand_r  <= wmag;
            mplier_r <= nmag;
            prod_r   <= '0;
            neg_r    <= w_r[63] ^ num[NW-1];
            step_r   <= '0;
          end
          W_MUL: begin
            if (step_r == SW'(NW)) begin
              dvd_r  <= prod_r[63:16];
              rem_r  <= '0;
              step_r <= '0;
            end else begin
              if (mplier_r[0]) prod_r <= prod_r + mcand_r;
              mcand_r  <= mcand_r << 1;
              mplier_r <= mplier_r >> 1;
              step_r   <= step_r + SW'(1);
            end
          end
          W_DIV: begin
            if (step_r != SW'(QW)) begin
              if (rem_t >= {1'b0, den}) begin
                rem_r <= (HW+1)'(rem_t - {1'b0, den});
                dvd_r <= {dvd_r[QW-2:0], 1'b1};
              end else begin
                rem_r <= rem_t[HW:0];
                dvd_r <= {dvd_r[QW-2:0], 1'b0};
              end
              step_r <= step_r + SW'(1);
            end
          end
          W_STORE: begin
            wt_r[i_r] <= w_new;
            w_r       <= w_new;
            i_r       <= i_r + HW'(1);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/nfd_back.sv
module nfd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  nfd_pkg::item_t         head_item,
  output logic                   pop,
  input  nfd_pkg::coef_t         coef,
  input  logic                   wgt_busy,
  output logic [nfd_pkg::HW-1:0] wgt_idx,
  input  logic signed [63:0]     weight,
  output nfd_pkg::mul_req_t      mreq,
  input  nfd_pkg::mul_rsp_t      mrsp,
  output logic                   init_done,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [79:0]            out_tdata,  // out_index[11:0], mass_term[43:12], damp_term[75:44]
  output logic                   out_tuser   // saturated
);
  import nfd_pkg::*;

  logic [31:0]      fd_mem [NUM_DOFS];
  logic [31:0]      sd_mem [NUM_DOFS];
  logic [31:0]      pv_mem [NUM_DOFS];
  logic [31:0]      pq_mem [NUM_DOFS];
  logic [ROW_W-1:0] hist_mem [NUM_DOFS];

  logic signed [31:0] fd_rd, sd_rd, pv_rd, pq_rd;
  logic [ROW_W-1:0]   hist_rd;

  back_state_t        st_r, st_nxt;
  logic [AW-1:0]      clr_r, waddr, raddr;
  logic               issued_r, ov_r, clip_r, mul_st, load_out;
  logic               re, we_a, we_b;
  item_t              item_r;
  logic signed [63:0] t1_r, t2_r, acc_r;
  logic signed [31:0] pvn_r, sdn_r, mass_r, damp_r;
  logic [HW-1:0]      hcnt_r;
  logic [79:0]        od_r;
  logic               ou_r;
  logic [31:0]        pv_wd, pq_wd, fd_wd, sd_wd, pv_n, pq_n, fd_n;
  logic [ROW_W-1:0]   hist_wd;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  assign raddr     = AW'(head_item.idx);
  assign waddr     = (st_r == B_CLR) ? clr_r : AW'(item_r.idx);
  assign wgt_idx   = hcnt_r;
  assign init_done = (st_r != B_CLR);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    re       = 1'b0;
    we_a     = 1'b0;
    we_b     = 1'b0;
    mul_st   = 1'b0;
    load_out = 1'b0;
    mreq     = '0;
    pv_wd    = '0;
    pq_wd    = '0;
    fd_wd    = '0;
    sd_wd    = '0;
    hist_wd  = '0;
    pv_n = sat32(64'($signed(item_r.sample)) + t1_r + t2_r);
    pq_n = sat32(64'(fd_rd) + mrsp.res);
    fd_n = sat32(64'(pq_rd) + mrsp.res);
    unique case (st_r)
      B_CLR: begin
        we_a = 1'b1;
        we_b = 1'b1;
        if (clr_r == AW'(NUM_DOFS - 1)) st_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (head_valid && !wgt_busy) begin
          pop    = 1'b1;
          re     = 1'b1;
          st_nxt = B_RD;
        end
      end
      B_RD: st_nxt = (item_r.op == OP_PREDICT) ? B_T1 : B_CA;
      B_T1: begin
        mul_st = 1'b1;
        mreq.a = 64'(fd_rd);
        mreq.b = {1'b0, coef.dt};
        mreq.sh = SH32;
        mreq.lim = LIM48;
        if (mrsp.done) st_nxt = B_T2;
      end
      B_T2: begin
        mul_st = 1'b1;
        mreq.a = 64'(sd_rd);
        mreq.b = coef.cps;
        mreq.sh = SH32;
        mreq.lim = LIM48;
        if (mrsp.done) st_nxt = B_T3;
      end
      B_T3: begin
        mul_st = 1'b1;
        mreq.a = 64'(sd_rd);
        mreq.b = coef.cpf;
        mreq.sh = SH32;
        mreq.lim = LIM48;
        if (mrsp.done) begin
          we_a   = 1'b1;
          pv_wd  = pv_n;
          pq_wd  = pq_n;
          st_nxt = B_MASS;
        end
      end
      B_MASS: begin
        mul_st = 1'b1;
        mreq.a = 64'(pvn_r);
        mreq.b = coef.cmass;
        mreq.sh = SH32;
        mreq.lim = LIM32;
        if (mrsp.done) st_nxt = B_HIST;
      end
      B_HIST: begin
        mul_st = 1'b1;
        mreq.a = weight;
        mreq.b = 64'($signed(hist_rd[hcnt_r*32 +: 32]));
        mreq.sh = SH16;
        mreq.lim = LIM64;
        if (mrsp.done && hcnt_r == HW'(HIST_DEPTH - 1)) st_nxt = B_DAMP;
      end
      B_DAMP: begin
        mul_st = 1'b1;
        mreq.a = acc_r;
        mreq.b = coef.dscale;
        mreq.sh = SH48;
        mreq.lim = LIM32;
        if (mrsp.done) st_nxt = B_OUT;
      end
      B_OUT: begin
        if (!ov_r || out_tready) begin
          load_out = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      B_CA: begin
        mul_st = 1'b1;
        mreq.a = 64'($signed(item_r.sample)) - 64'(pv_rd);
        mreq.b = coef.cmass;
        mreq.sh = SH32;
        mreq.lim = LIM48;
        if (mrsp.done) st_nxt = B_CT;
      end
      B_CT: begin
        mul_st = 1'b1;
        mreq.a = 64'(sdn_r);
        mreq.b = coef.ccf;
        mreq.sh = SH32;
        mreq.lim = LIM48;
        if (mrsp.done) begin
          we_b    = 1'b1;
          fd_wd   = fd_n;
          sd_wd   = sdn_r;
          hist_wd = ROW_W'({hist_rd, item_r.sample});
          st_nxt  = B_IDLE;
        end
      end
      default: st_nxt = B_CLR;
    endcase
    mreq.start = mul_st && !issued_r;
  end

  always_ff @(posedge clk) begin
    if (re) begin
      fd_rd   <= fd_mem[raddr];
      sd_rd   <= sd_mem[raddr];
      pv_rd   <= pv_mem[raddr];
      pq_rd   <= pq_mem[raddr];
      hist_rd <= hist_mem[raddr];
    end
    if (we_a) begin
      pv_mem[waddr] <= pv_wd;
      pq_mem[waddr] <= pq_wd;
    end
    if (we_b) begin
      fd_mem[waddr]   <= fd_wd;
      sd_mem[waddr]   <= sd_wd;
      hist_mem[waddr] <= hist_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_CLR;
      clr_r    <= '0;
      issued_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_CLR) clr_r <= clr_r + AW'(1);
      if (mreq.start) issued_r <= 1'b1;
      else if (mrsp.done) issued_r <= 1'b0;
      if (load_out) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= head_item;
    if (mrsp.done) begin
      case (st_r)
        B_T1: t1_r <= mrsp.res;
        B_T2: t2_r <= mrsp.res;
        B_T3: pvn_r <= pv_n;
        B_MASS: begin
          mass_r <= mrsp.res[31:0];
          clip_r <= mrsp.clip;
          acc_r  <= '0;
          hcnt_r <= '0;
        end
        B_HIST: begin
          acc_r  <= acc_r + mrsp.res;
          hcnt_r <= hcnt_r + HW'(1);
        end
        B_DAMP: begin
          damp_r <= mrsp.res[31:0];
          clip_r <= clip_r | mrsp.clip;
        end
        B_CA: sdn_r <= sat32(mrsp.res);
        default: ;
      endcase
    end
    if (load_out) begin
      od_r <= {4'b0, damp_r, mass_r, item_r.idx};
      ou_r <= clip_r;
    end
  end

endmodule

>>> rtl/newmark_fractional_damping_step.sv
// Newmark-beta step with fractional (Grunwald-Letnikov) damping, one degree of
// freedom per item. Items are queued two deep and executed one at a time on a
// single shared 64x64 multiply unit built from four 33x33 partial products.
// A predict item takes three predictor products, the mass product, one product
// per history tap and the damping scale, plus dequeue, read and output steps; a
// correct item takes two products plus dequeue and read. After reset a clearing
// pass writes zero to every degree of freedom, one per cycle, and no item is
// taken meanwhile. The weights are rebuilt after reset and after each
// frac_order write by a shift-add multiplier and a restoring divider; queued
// items wait for the rebuild.
module newmark_fractional_damping_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,     // dof_index[11:0], sample_value[43:12]
  input  logic        in_tuser,     // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,    // out_index[11:0], mass_term[43:12], damp_term[75:44]
  output logic        out_tuser,    // saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import nfd_pkg::*;
`include "newmark_fractional_damping_step_defines.svh"

  coef_t         coef_r;
  logic [16:0]   frac_r;
  logic          wr, frac_wr, init_done, pop, head_valid, wgt_busy;
  logic [2:0]    ridx;
  item_t         head_item;
  mul_req_t      mreq;
  mul_rsp_t      mrsp;
  logic [HW-1:0] wgt_idx;
  logic signed [63:0] weight;

  assign cfg_pready = 1'b1;
  assign ridx    = cfg_paddr[5:3];
  assign wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign frac_wr = wr && (ridx == REG_FRAC_ORDER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      frac_r <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_PRED_SECOND: coef_r.cps    <= cfg_pwdata;
        REG_PRED_FIRST:  coef_r.cpf    <= cfg_pwdata;
        REG_MASS:        coef_r.cmass  <= cfg_pwdata;
        REG_CORR_FIRST:  coef_r.ccf    <= cfg_pwdata;
        REG_STEP_DT:     coef_r.dt     <= cfg_pwdata[62:0];
        REG_FRAC_ORDER:  frac_r        <= cfg_pwdata[16:0];
        REG_DAMP_SCALE:  coef_r.dscale <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_PRED_SECOND: cfg_prdata = coef_r.cps;
      REG_PRED_FIRST:  cfg_prdata = coef_r.cpf;
      REG_MASS:        cfg_prdata = coef_r.cmass;
      REG_CORR_FIRST:  cfg_prdata = coef_r.ccf;
      REG_STEP_DT:     cfg_prdata = {1'b0, coef_r.dt};
      REG_FRAC_ORDER:  cfg_prdata = {47'b0, frac_r};
      REG_DAMP_SCALE:  cfg_prdata = coef_r.dscale;
      default:         cfg_prdata = '0;
    endcase
  end

  nfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (init_done),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  nfd_weights u_weights (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (frac_wr),
    .frac   (frac_r),
    .rd_idx (wgt_idx),
    .busy   (wgt_busy),
    .weight (weight)
  );

  nfd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  nfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .coef       (coef_r),
    .wgt_busy   (wgt_busy),
    .wgt_idx    (wgt_idx),
    .weight     (weight),
    .mreq       (mreq),
    .mrsp       (mrsp),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `NFD_ASSERT_NOW(a_no_take_in_clear, !init_done, !in_tready)
  `NFD_ASSERT_NEXT(a_wgt_restart, frac_wr, wgt_busy)
  `NFD_ASSERT_NOW(a_sat_at_limit, out_tvalid && out_tuser, (out_tdata[43:12] == 32'h7FFF_FFFF) || (out_tdata[43:12] == 32'h8000_0000) || (out_tdata[75:44] == 32'h7FFF_FFFF) || (out_tdata[75:44] == 32'h8000_0000))

endmodule

>>> bench/newmark_fractional_damping_step_tb.sv
`timescale 1ns / 100ps

module newmark_fractional_damping_step_tb;
  import nfd_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE = 400;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] mass;
    logic [31:0] damp;
    logic        sat;
  } dof_result_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [47:0] in_tdata;
  logic        out_tvalid, out_tready, out_tuser;
  logic [79:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;

  newmark_fractional_damping_step dut (.*);

  // local copy of block state
  longint c_pred_second, c_pred_first, c_mass, c_corr_first, c_dt, c_dscale;
  int unsigned c_order;
  int vel[NUM_DOFS], acc[NUM_DOFS], pval[NUM_DOFS], pvel[NUM_DOFS];
  int hist[NUM_DOFS][HIST_DEPTH];
  longint gl_weight[HIST_DEPTH];

  item_t       pending_items[$];
  dof_result_t pending_results[$];
  int unsigned errors = 0, idle_in = 0, idle_out = 0, quiet_cycles = 0;
  bit          in_taken, hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint mul_sh(longint a, longint b, int sh, longint lim, inout bit clip);
    logic signed [127:0] pa, pb, v, l;
    pa = a;
    pb = b;
    l = lim;
    v = (pa * pb) >>> sh;
    if (v > l) begin
      clip = 1;
      return lim;
    end
    if (v < -l - 1) begin
      clip = 1;
      return -lim - 1;
    end
    return longint'(v);
  endfunction

  function automatic int clip32(longint v, inout bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clip = 1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic void build_weights();
    longint w;
    w = 64'sd1 << 32;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      w = (w * ((longint'(i) - 1) * 65536 - longint'(c_order))) / ((longint'(i) + 1) * 65536);
      gl_weight[i] = w;
    end
  endfunction

  function automatic void set_register(int r, logic [63:0] v);
    case (r)
      REG_PRED_SECOND: c_pred_second = v;
      REG_PRED_FIRST:  c_pred_first = v;
      REG_MASS:        c_mass = v;
      REG_CORR_FIRST:  c_corr_first = v;
      REG_STEP_DT:     c_dt = {1'b0, v[62:0]};
      REG_FRAC_ORDER: begin
        c_order = v[16:0];
        build_weights();
      end
      REG_DAMP_SCALE:  c_dscale = v;
      default: ;
    endcase
  endfunction

  function automatic void step_dof(item_t it);
    bit junk, clip;
    longint t1, t2, t3, sum, m, dmp, a;
    int d;
    dof_result_t r;
    junk = 0;
    clip = 0;
    sum = 0;
    d = it.idx;
    if (it.op == OP_PREDICT) begin
      t1 = mul_sh(vel[d], c_dt, 32, 64'sh7fffffffffff, junk);
      t2 = mul_sh(acc[d], c_pred_second, 32, 64'sh7fffffffffff, junk);
      t3 = mul_sh(acc[d], c_pred_first, 32, 64'sh7fffffffffff, junk);
      pval[d] = clip32(longint'(it.sample) + t1 + t2, junk);
      pvel[d] = clip32(longint'(vel[d]) + t3, junk);
      m = mul_sh(pval[d], c_mass, 32, 64'sh7fffffff, clip);
      for (int i = 0; i < HIST_DEPTH; i++)
        sum += mul_sh(gl_weight[i], hist[d][i], 16, 64'sh7fffffffffffffff, junk);
      dmp = mul_sh(sum, c_dscale, 48, 64'sh7fffffff, clip);
      r.idx = it.idx;
      r.mass = m[31:0];
      r.damp = dmp[31:0];
      r.sat = clip;
      pending_results.push_back(r);
    end else begin
      a = mul_sh(longint'(it.sample) - pval[d], c_mass, 32, 64'sh7fffffffffff, junk);
      acc[d] = clip32(a, junk);
      t1 = mul_sh(acc[d], c_corr_first, 32, 64'sh7fffffffffff, junk);
      vel[d] = clip32(longint'(pvel[d]) + t1, junk);
      for (int i = HIST_DEPTH - 1; i > 0; i--)
        hist[d][i] = hist[d][i - 1];
      hist[d][0] = it.sample;
    end
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_out);
      if (!(in_tvalid && !in_taken)) begin
        if (pending_items.size() > 0 && !hold_off && $urandom_range(99) >= idle_in) begin
          item_t it;
          it = pending_items.pop_front();
          in_tvalid <= 1;
          in_tuser <= it.op;
          in_tdata <= {4'b0, it.sample, it.idx};
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dof_result_t e;
    in_taken = in_tvalid && in_tready;
    if (in_taken) step_dof(item_t'{op_t'(in_tuser), in_tdata[11:0], in_tdata[43:12]});
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual idx=%0d mass=%h damp=%h sat=%b", $time,
                 out_tdata[11:0], out_tdata[43:12], out_tdata[75:44], out_tuser);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[11:0] !== e.idx || out_tdata[43:12] !== e.mass ||
            out_tdata[75:44] !== e.damp || out_tuser !== e.sat) begin
          $display("%0t mismatch: expected idx=%0d mass=%h damp=%h sat=%b", $time,
                   e.idx, e.mass, e.damp, e.sat);
          $display("%0t           actual   idx=%0d mass=%h damp=%h sat=%b", $time,
                   out_tdata[11:0], out_tdata[43:12], out_tdata[75:44], out_tuser);
          errors++;
        end
      end
    end
    if (in_taken || (out_tvalid && out_tready) || cfg_psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(int r, logic [63:0] v);
    @(negedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= 6'(r * 8);
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    set_register(r, v);
  endtask

  function automatic logic [63:0] rand_coef();
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    return v >>> $urandom_range(63);
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3, 4: return $urandom;
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic configure(int setting);
    logic [63:0] v[7];
    case (setting)
      0: v = '{64'd107374, 64'd21474836, 64'd171798691840000, 64'd21474836,
               64'd42949673, 64'd32768, 64'd4294967296000};
      1: v = '{64'h7fffffffffffffff, 64'h7fffffffffffffff, 64'h7fffffffffffffff,
               64'h7fffffffffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff,
               64'h7fffffffffffffff};
      2: v = '{64'h8000000000000000, 64'h8000000000000000, 64'h8000000000000000,
               64'h8000000000000000, 64'h0, 64'h0, 64'h8000000000000000};
      default: begin
        for (int i = 0; i < 7; i++) v[i] = rand_coef();
        v[REG_STEP_DT] = {$urandom, $urandom};
        v[REG_FRAC_ORDER] = {$urandom, $urandom};
      end
    endcase
    for (int i = 0; i < 7; i++) reg_write(i, v[i]);
    reg_write(7, {$urandom, $urandom});
  endtask

  task automatic add_random(int n);
    item_t it;
    int d;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 75) begin
        d = ($urandom_range(9) == 0) ? $urandom_range(NUM_DOFS - 1) : $urandom_range(15);
        pending_items.push_back(item_t'{OP_PREDICT, 12'(d), rand_sample()});
        pending_items.push_back(item_t'{OP_CORRECT, 12'(d), rand_sample()});
        k++;
      end else begin
        it.op = op_t'($urandom_range(1));
        it.idx = 12'($urandom_range(NUM_DOFS - 1));
        it.sample = rand_sample();
        pending_items.push_back(it);
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || pending_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    c_pred_second = 0; c_pred_first = 0; c_mass = 0; c_corr_first = 0;
    c_dt = 0; c_dscale = 0; c_order = 0;
    foreach (vel[i]) begin
      vel[i] = 0; acc[i] = 0; pval[i] = 0; pvel[i] = 0;
      for (int j = 0; j < HIST_DEPTH; j++) hist[i][j] = 0;
    end
    build_weights();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset-value predict, then directed sequences
    pending_items.push_back(item_t'{OP_PREDICT, 12'd0, 32'd0});
    drain();
    configure(0);
    pending_items.push_back(item_t'{OP_PREDICT, 12'd0, 32'h7fffffff});
    pending_items.push_back(item_t'{OP_CORRECT, 12'd0, 32'h7fffffff});
    pending_items.push_back(item_t'{OP_PREDICT, 12'd4095, 32'h80000000});
    pending_items.push_back(item_t'{OP_CORRECT, 12'd4095, 32'h80000000});
    for (int k = 0; k < 18; k++)
      pending_items.push_back(item_t'{op_t'(k % 2), 12'd1, 32'(k * 32'h00010000)});
    pending_items.push_back(item_t'{OP_PREDICT, 12'd4095, 32'h0});
    pending_items.push_back(item_t'{OP_PREDICT, 12'd1, 32'hffffffff});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      configure((ph < 3) ? ph : 3);
      case (ph % 4)
        0: begin idle_in = 0;  idle_out = 0;  end
        1: begin idle_in = 76; idle_out = 0;  end
        2: begin idle_in = 0;  idle_out = 76; end
        default: begin idle_in = 35; idle_out = 35; end
      endcase
      add_random(200);
      drain();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/nfd_pkg.sv
rtl/nfd_front.sv
rtl/nfd_mul.sv
rtl/nfd_weights.sv
rtl/nfd_back.sv
rtl/newmark_fractional_damping_step.sv
bench/newmark_fractional_damping_step_tb.sv
